FILE: design/aabq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabq_pkg: shared types and constants of the ASCII-art block quantizer
// Holds luma weights, character table, threshold table and the command and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package aabq_pkg;

  localparam int SUM_W = 17;
  localparam logic [SUM_W-1:0] SUM_MAX = 17'd131071;

  // Luma weights 0.2126, 0.7152, 0.0722 in unsigned 0.16 fixed point.
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam int NUM_GLYPHS = 10;
  localparam logic [3:0] LAST_STEP = 4'd9;

  typedef struct packed {
    logic       load;       // Input transfer: capture pixel, issue sum read.
    logic       read_cap;   // Sum read data and luma are captured.
    logic       acc;        // Write back the sum and advance the counters.
    logic       cls_clear;  // Restart the character index.
    logic       cls_step;   // Compare against one threshold.
    logic [3:0] cls_k;      // Threshold number, 1 to 9.
    logic       out_load;   // Load the output register.
  } cmd_t;

  typedef struct packed {
    logic emit;             // The pixel completed a full block.
  } sts_t;

  // An average reaches index k exactly when it is at least ceil(25.6 * k).
  function automatic logic [7:0] threshold(input logic [3:0] k);
    logic [7:0] t;
    case (k)
      4'd1:    t = 8'd26;
      4'd2:    t = 8'd52;
      4'd3:    t = 8'd77;
      4'd4:    t = 8'd103;
      4'd5:    t = 8'd128;
      4'd6:    t = 8'd154;
      4'd7:    t = 8'd180;
      4'd8:    t = 8'd205;
      4'd9:    t = 8'd231;
      default: t = 8'd255;
    endcase
    return t;
  endfunction

  // Character ramp "@%#=+|!:. " from dark to light.
  function automatic logic [6:0] glyph(input logic [3:0] idx);
    logic [6:0] g;
    case (idx)
      4'd0:    g = 7'd64;
      4'd1:    g = 7'd37;
      4'd2:    g = 7'd35;
      4'd3:    g = 7'd61;
      4'd4:    g = 7'd43;
      4'd5:    g = 7'd124;
      4'd6:    g = 7'd33;
      4'd7:    g = 7'd58;
      4'd8:    g = 7'd46;
      default: g = 7'd32;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: design/aabq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabq_ctrl: sequencing controller
// Steps each pixel through read, accumulate and, for completed blocks, the
// nine threshold compares, and owns the output valid flag.
// ----------------------------------------------------------------------------
module aabq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire aabq_pkg::sts_t sts,
  output aabq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_CLASS, S_DONE} state_t;

  state_t     state_r;
  logic [3:0] k_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.cls_k     = k_r;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.read_cap  = (state_r == S_READ);
    cmd.acc       = (state_r == S_ACC);
    cmd.cls_clear = (state_r == S_ACC);
    cmd.cls_step  = (state_r == S_CLASS);
    cmd.out_load  = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          k_r     <= 4'd1;
          state_r <= sts.emit ? S_CLASS : S_IDLE;
        end
        S_CLASS: begin
          if (k_r == aabq_pkg::LAST_STEP) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/aabq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabq_datapath: luma, block sums, counters and character selection
// Holds the configuration registers, the per-column sum memory with its
// fill count, the raster counters and the threshold compare.
// ----------------------------------------------------------------------------
module aabq_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  input  wire logic           cfg_index,
  input  wire logic [10:0]    cfg_data,
  input  wire logic [7:0]     in_red,
  input  wire logic [7:0]     in_green,
  input  wire logic [7:0]     in_blue,
  input  wire logic           in_frame_start,
  output logic [6:0]          out_symbol,
  output logic                out_row_end,
  input  wire aabq_pkg::cmd_t cmd,
  output aabq_pkg::sts_t      sts
);

  localparam int SW  = aabq_pkg::SUM_W;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int BBW = $clog2(MAX_BLOCK + 1);
  localparam int RW  = $clog2(2 * MAX_BLOCK + 1);
  localparam int P1W = EW + BBW + 1;
  localparam int ARW = 2 * BBW + 1;
  localparam int PW  = (ARW + 8 > SW) ? ARW + 8 : SW;

  localparam logic CFG_IMAGE_WIDTH = 1'b0;
  localparam logic CFG_BLOCK_WIDTH = 1'b1;

  logic [10:0]    image_width_r;
  logic [4:0]     block_width_r;
  logic [EW-1:0]  w_eff;
  logic [BBW-1:0] bw_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 11'd640;
      block_width_r <= 5'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data;
        CFG_BLOCK_WIDTH: block_width_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r == 11'd0) begin
      w_eff = EW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width_r);
    end
    if (block_width_r == 5'd0) begin
      bw_eff = BBW'(1);
    end else if (int'(block_width_r) > MAX_BLOCK) begin
      bw_eff = BBW'(MAX_BLOCK);
    end else begin
      bw_eff = BBW'(block_width_r);
    end
  end

  // Raster counters and the fill count of the sum memory. Entries at and
  // above the fill count have not been written since the last clear.
  logic [EW-1:0]  cc_r;
  logic [BBW-1:0] cib_r;
  logic [AW-1:0]  bc_r;
  logic [RW-1:0]  rib_r;
  logic [EW-1:0]  fill_r;

  logic [7:0]     red_r, green_r, blue_r;
  logic [7:0]     luma_r;
  logic [SW-1:0]  mem_q;
  logic [SW-1:0]  old_r;
  logic [P1W-1:0] p1_r;
  logic [SW-1:0]  sum_r;
  logic [ARW-1:0] area_r;
  logic [3:0]     idx_r;
  logic           last_r;
  logic [SW-1:0]  acc_sum;

  logic [SW-1:0]  mem [MAX_WIDTH];
  logic [AW-1:0]  rd_addr;

  assign rd_addr = in_frame_start ? '0 : bc_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_q <= mem[rd_addr];
    end
    if (cmd.acc) begin
      mem[bc_r] <= acc_sum;
    end
  end

  logic [23:0] W_R_PROD, W_G_PROD, W_B_PROD;
  assign W_R_PROD = 24'(red_r)   * 24'(aabq_pkg::W_RED);
  assign W_G_PROD = 24'(green_r) * 24'(aabq_pkg::W_GREEN);
  assign W_B_PROD = 24'(blue_r)  * 24'(aabq_pkg::W_BLUE);

  logic [23:0] luma_full;
  assign luma_full = 24'(W_R_PROD) + 24'(W_G_PROD) + 24'(W_B_PROD);

  // Accumulate step.
  logic            in_block;
  logic [SW:0]     sat_in;
  logic [P1W-1:0]  p2;
  logic            emit;
  logic [EW:0]     cc_inc;
  logic [BBW:0]    cib_inc;
  logic [AW:0]     bc_inc;
  logic [RW:0]     rib_inc;
  logic [EW-1:0]   cc_nxt;
  logic [BBW-1:0]  cib_nxt;
  logic [AW:0]     bc_nxt;
  logic [RW-1:0]   rib_nxt;
  logic            blk_row_done;

  always_comb begin
    in_block = (p1_r <= P1W'(w_eff));
    sat_in   = {1'b0, old_r} + (SW + 1)'(luma_r);
    if (!in_block) begin
      acc_sum = old_r;
    end else if (sat_in > (SW + 1)'(aabq_pkg::SUM_MAX)) begin
      acc_sum = aabq_pkg::SUM_MAX;
    end else begin
      acc_sum = sat_in[SW-1:0];
    end
    p2   = p1_r + P1W'(bw_eff);
    emit = in_block && ((BBW + 1)'(cib_r) + 1'b1 >= (BBW + 1)'(bw_eff))
        && ((RW + 1)'(rib_r) + 1'b1 >= (RW + 1)'({bw_eff, 1'b0}));

    cc_inc  = (EW + 1)'(cc_r) + 1'b1;
    cib_inc = (BBW + 1)'(cib_r) + 1'b1;
    bc_nxt  = (AW + 1)'(bc_r);
    cib_nxt = cib_inc[BBW-1:0];
    if (cib_inc >= (BBW + 1)'(bw_eff)) begin
      cib_nxt = '0;
      bc_nxt  = bc_nxt + 1'b1;
    end
    cc_nxt       = cc_inc[EW-1:0];
    rib_nxt      = rib_r;
    blk_row_done = 1'b0;
    rib_inc      = (RW + 1)'(rib_r) + 1'b1;
    if (cc_inc >= (EW + 1)'(w_eff)) begin
      cc_nxt  = '0;
      cib_nxt = '0;
      bc_nxt  = '0;
      rib_nxt = rib_inc[RW-1:0];
      if (rib_inc >= (RW + 1)'({bw_eff, 1'b0})) begin
        rib_nxt      = '0;
        blk_row_done = 1'b1;
      end
    end
    if (bc_nxt >= (AW + 1)'(MAX_WIDTH)) begin
      bc_nxt = (AW + 1)'(MAX_WIDTH - 1);
    end
    bc_inc = (AW + 1)'(bc_r) + 1'b1;
  end

  assign sts.emit = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= '0;
      cib_r  <= '0;
      bc_r   <= '0;
      rib_r  <= '0;
      fill_r <= '0;
    end else if (cmd.load && in_frame_start) begin
      cc_r   <= '0;
      cib_r  <= '0;
      bc_r   <= '0;
      rib_r  <= '0;
      fill_r <= '0;
    end else if (cmd.acc) begin
      cc_r  <= cc_nxt;
      cib_r <= cib_nxt;
      bc_r  <= bc_nxt[AW-1:0];
      rib_r <= rib_nxt;
      if (blk_row_done) begin
        fill_r <= '0;
      end else if ((EW)'(bc_r) == fill_r) begin
        fill_r <= EW'(bc_inc);
      end
    end
  end

  // Payload registers.
  logic [PW-1:0] thr_prod;
  assign thr_prod = PW'(area_r) * PW'(aabq_pkg::threshold(cmd.cls_k));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (cmd.read_cap) begin
      luma_r <= luma_full[23:16];
      old_r  <= ((EW)'(bc_r) < fill_r) ? mem_q : '0;
      p1_r   <= P1W'(bc_inc) * P1W'(bw_eff);
    end
    if (cmd.acc) begin
      sum_r  <= acc_sum;
      last_r <= (p2 > P1W'(w_eff));
      area_r <= ARW'({bw_eff, 1'b0}) * ARW'(bw_eff);
    end
    if (cmd.cls_clear) begin
      idx_r <= '0;
    end else if (cmd.cls_step && (PW'(sum_r) >= thr_prod)) begin
      idx_r <= idx_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_symbol  <= aabq_pkg::glyph(idx_r);
      out_row_end <= last_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/ascii_art_block_quantizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each pixel transfer reads its column sum, captures the read data and luma,
// and writes the updated sum back, a read-modify-write of the column sum
// memory; a pixel that completes a block then runs nine threshold compares
// on one multiplier and loads its character into the output register once
// the output is free. No new pixel is taken until the last one is done.
// Reset (rst_n low, synchronous) clears counters, the sum fill count and
// valid flags, and loads image_width 640 and block_width 4.
// ----------------------------------------------------------------------------
// ascii_art_block_quantizer_top: RGB raster stream to ASCII-art characters
// Converts each pixel to luma, sums luma over block_width by 2*block_width
// blocks per block column, and emits one character per completed block.
// ----------------------------------------------------------------------------
module ascii_art_block_quantizer_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_symbol,
  output logic             out_row_end
);

  aabq_pkg::cmd_t cmd;
  aabq_pkg::sts_t sts;

  // Configuration writes are always taken; users must write only while idle.
  assign cfg_ready = 1'b1;

  // The controller sequences each pixel transfer and owns output valid.
  aabq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the column sums, whose stale entries are masked by a
  // fill count that frame start and each finished block row reset to zero.
  aabq_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .out_symbol     (out_symbol),
    .out_row_end    (out_row_end),
    .cmd            (cmd),
    .sts            (sts)
  );

  // A pixel transfer always keeps the block busy on the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a pixel was still in work");

  // A new result appears only while the pipeline is busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in work");

  // Only characters of the ramp are ever shown.
  a_glyph_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol == 7'd64 || out_symbol == 7'd37 ||
      out_symbol == 7'd35 || out_symbol == 7'd61 || out_symbol == 7'd43 ||
      out_symbol == 7'd124 || out_symbol == 7'd33 || out_symbol == 7'd58 ||
      out_symbol == 7'd46 || out_symbol == 7'd32))
    else $error("symbol outside the character ramp");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_symbol)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: test/tb_ascii_art_block_quantizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_art_block_quantizer_top: self-checking bench of the block quantizer
// Streams RGB pixels under several image and block geometries, predicts every
// block character in the bench and compares each output transfer in order.
// ----------------------------------------------------------------------------
module tb_ascii_art_block_quantizer_top;

  localparam int MAX_W = 1024;
  localparam int MAX_B = 16;
  localparam int CYCLE_LIMIT = 400000;
  // Register indexes of the configuration port.
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_BLOCK_WIDTH = 1'b1;
  // Cycles to let pass after the last character so a block in flight drains.
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_symbol;
  logic        out_row_end;

  ascii_art_block_quantizer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_row_end    (out_row_end)
  );

  always #6 clk = ~clk;

  // Pixels waiting for the driver, and the characters the bench expects.
  pixel_t     pixel_q[$];
  logic [6:0] symbol_q[$];
  logic       row_end_q[$];
  int         error_count = 0;
  int         cycle_count = 0;
  // When set, both sides insert random gaps; when clear, they run flat out.
  bit         gaps_on = 1'b1;

  // Shadow of the block state: registers, column sums and raster counters.
  logic [10:0] shadow_width = 11'd640;
  logic [4:0]  shadow_block = 5'd4;
  logic [16:0] col_sum[MAX_W];
  int unsigned pix_col, col_in_blk, blk_col, row_in_blk;
  string       glyph_ramp = "@%#=+|!:. ";

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 13) : 0;
  endfunction

  task automatic clear_raster();
    foreach (col_sum[i]) col_sum[i] = '0;
    pix_col = 0;
    col_in_blk = 0;
    blk_col = 0;
    row_in_blk = 0;
  endtask

  // Advances the shadow state by one accepted pixel and queues the character
  // that the pixel produces when it completes a full block.
  task automatic predict_block_char(input pixel_t px);
    int unsigned w, bw, nblk, luma, s, avg;
    w = shadow_width;
    bw = shadow_block;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (bw < 1) bw = 1;
    if (bw > MAX_B) bw = MAX_B;
    nblk = w / bw;
    if (px.frame_start) clear_raster();
    luma = (13933 * px.red + 46871 * px.green + 4732 * px.blue) >> 16;
    if (blk_col < nblk) begin
      s = col_sum[blk_col] + luma;
      if (s > 131071) s = 131071;
      col_sum[blk_col] = s[16:0];
      if (col_in_blk >= bw - 1 && row_in_blk >= 2 * bw - 1) begin
        avg = s / (2 * bw * bw);
        if (avg > 255) avg = 255;
        symbol_q.push_back(7'(glyph_ramp[(avg * 10) >> 8]));
        row_end_q.push_back(blk_col == nblk - 1);
      end
    end
    pix_col++;
    col_in_blk++;
    if (col_in_blk >= bw) begin
      col_in_blk = 0;
      blk_col++;
    end
    if (pix_col >= w) begin
      pix_col = 0;
      col_in_blk = 0;
      blk_col = 0;
      row_in_blk++;
      if (row_in_blk >= 2 * bw) begin
        row_in_blk = 0;
        foreach (col_sum[i]) col_sum[i] = '0;
      end
    end
    if (blk_col >= MAX_W) blk_col = MAX_W - 1;
  endtask

  // Input driver. A transfer happens when valid is high and stall is low; the
  // next pixel follows in the same edge when its drawn gap is zero, so valid
  // stays high without being lowered and raised in one step.
  int     in_gap = 0;
  pixel_t next_px;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_block_char('{in_red, in_green, in_blue, in_frame_start});
        in_gap = draw_gap();
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (in_gap == 0 && pixel_q.size() > 0) begin
          next_px = pixel_q.pop_front();
          in_red <= next_px.red;
          in_green <= next_px.green;
          in_blue <= next_px.blue;
          in_frame_start <= next_px.frame_start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end
      end
    end
  end

  // Output monitor with random back-pressure drawn per character.
  int out_hold = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (symbol_q.size() == 0) begin
          $display("%0t: unexpected character transfer, symbol %0d row_end %0b",
                   $time, out_symbol, out_row_end);
          error_count++;
        end else begin
          if (out_symbol !== symbol_q[0]) begin
            $display("%0t: symbol mismatch, expected %0d actual %0d",
                     $time, symbol_q[0], out_symbol);
            error_count++;
          end
          if (out_row_end !== row_end_q[0]) begin
            $display("%0t: row_end mismatch, expected %0b actual %0b",
                     $time, row_end_q[0], out_row_end);
            error_count++;
          end
          void'(symbol_q.pop_front());
          void'(row_end_q.pop_front());
        end
        out_hold = draw_gap();
        out_stall <= (out_hold != 0);
      end else if (out_hold > 0) begin
        out_hold--;
        out_stall <= (out_hold != 0);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_pixel(input int r, input int g, input int b, input bit fs);
    pixel_t px;
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    px.frame_start = fs;
    pixel_q.push_back(px);
  endtask

  // Random pixels; the first may open a new frame, and a rare stray frame
  // start lands in the middle of a frame.
  task automatic add_random(input int n, input bit open_frame);
    for (int i = 0; i < n; i++)
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                (i == 0 && open_frame) || ($urandom_range(0, 299) == 0));
  endtask

  // Waits until every pixel is in and every character out, then lets a
  // block still in the classifier drain.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || symbol_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_index <= idx;
    cfg_data <= val[10:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) shadow_width = val[10:0];
    else shadow_block = val[4:0];
  endtask

  task automatic new_geometry(input int w, input int bw, input bit gaps);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_BLOCK_WIDTH, bw);
    gaps_on = gaps;
  endtask

  initial begin
    clear_raster();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: no block completes in a few pixels.
    add_random(10, 1'b1);

    // Directed: 2-pixel-wide rows of 1x2 blocks. Gray pixels give luma equal
    // to the gray level; the first rows give a pure black and a pure white
    // block, then rising gray levels step through the character ramp.
    new_geometry(2, 1, 1'b1);
    add_pixel(0, 0, 0, 1'b1);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 1'b0);
    for (int k = 1; k <= 8; k++) begin
      add_pixel(26 * k, 26 * k, 26 * k, 1'b0);
      add_pixel(26 * k - 1, 26 * k - 1, 26 * k - 1, 1'b0);
    end
    add_pixel(255, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 1'b0);
    add_pixel(0, 0, 255, 1'b0);
    add_pixel(255, 255, 255, 1'b1);

    new_geometry(8, 1, 1'b0);
    add_random(200, 1'b1);
    new_geometry(12, 2, 1'b1);
    add_random(300, 1'b1);
    // Zero registers act as one.
    new_geometry(0, 0, 1'b1);
    add_random(60, 1'b0);
    // Widest block on a row that just holds it; bright pixels stop short of
    // the block end, then the frame continues under a narrow block so the
    // nearly full sum gives an average above the top of the ramp.
    new_geometry(16, 16, 1'b1);
    for (int i = 0; i < 500; i++) add_pixel(255, 255, $urandom_range(0, 255), i == 0);
    new_geometry(16, 1, 1'b0);
    add_random(60, 1'b0);
    // Out-of-range registers clamp to the maxima; widest legal row.
    new_geometry(2047, 31, 1'b1);
    add_random(20, 1'b1);
    new_geometry(1024, 5, 1'b1);
    add_random(20, 1'b0);
    // Block wider than the row: nothing is ever emitted.
    new_geometry(5, 8, 1'b1);
    add_random(30, 1'b1);
    // Partial blocks at the right edge.
    new_geometry(7, 3, 1'b1);
    add_random(200, 1'b1);

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: ascii_art_block_quantizer_top.f
design/aabq_pkg.sv
design/aabq_ctrl.sv
design/aabq_datapath.sv
design/ascii_art_block_quantizer_top.sv
test/tb_ascii_art_block_quantizer_top.sv
